>>> hw/rtl/pls_pkg.sv
// shared types and constants for the positional list store
// no dependencies; imported by pls_ctrl, pls_dp and positional_list_store
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;

  // operation kinds
  localparam logic [2:0] K_INS_FRONT = 3'd0;
  localparam logic [2:0] K_INS_BACK  = 3'd1;
  localparam logic [2:0] K_INS_POS   = 3'd2;
  localparam logic [2:0] K_DEL_FRONT = 3'd3;
  localparam logic [2:0] K_DEL_BACK  = 3'd4;
  localparam logic [2:0] K_DEL_POS   = 3'd5;
  localparam logic [2:0] K_READ_ALL  = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]              kind;
    logic [4:0]              position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] result_value;
    logic [CNT_W-1:0]        element_count;
    logic                    last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             mem_re;
    logic [IDX_W-1:0] raddr;
    logic             mem_we;
    logic [IDX_W-1:0] waddr;
    logic             wsel_val;
    logic             cap_res;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             out_load;
    logic [1:0]       out_status;
    logic             out_sel_rd;
    logic             out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             out_free;
  } sts_t;

endpackage

>>> hw/rtl/pls_dp.sv
// datapath of the positional list store: element memory, count, output register
// depends on pls_pkg
module pls_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [pls_pkg::VAL_W-1:0] in_value,
  input  pls_pkg::cmd_t                   cmd,
  output pls_pkg::sts_t                   sts,
  output logic                            out_valid,
  output pls_pkg::out_t                   out_data,
  input  logic                            out_stall
);
  import pls_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] res_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_r;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.waddr] <= cmd.wsel_val ? val_r : rdata_r;
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r <= in_value;
      res_r <= '0;
    end else if (cmd.cap_res) begin
      res_r <= rdata_r;
    end
    if (cmd.out_load) begin
      out_r.status        <= cmd.out_status;
      out_r.result_value  <= cmd.out_sel_rd ? rdata_r : res_r;
      out_r.element_count <= count_r;
      out_r.last          <= cmd.out_last;
    end
  end

  assign sts.count    = count_r;
  assign sts.out_free = out_free;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

>>> hw/rtl/pls_ctrl.sv
// controller of the positional list store: decodes operations, sequences shifts
// depends on pls_pkg
module pls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pls_pkg::in_t  in_data,
  output logic          in_stall,
  output pls_pkg::cmd_t cmd,
  input  pls_pkg::sts_t sts
);
  import pls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_EMIT,
    S_RD_REQ,
    S_RD_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic             first_r, first_nxt;
  logic             up_r, up_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             accept;
  logic [CNT_W-1:0] cnt_m1;
  logic [4:0]       pos_m1;
  logic [IDX_W-1:0] idx;
  logic             ins_bad;
  logic             del_bad;
  logic             rd_last;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign cnt_m1  = sts.count - CNT_W'(1);
  assign pos_m1  = in_data.position - 5'd1;
  assign ins_bad = (in_data.position == 5'd0) ||
                   ({1'b0, in_data.position} > ({1'b0, sts.count} + 6'd1));
  assign del_bad = (in_data.position == 5'd0) ||
                   (CNT_W'(in_data.position) > sts.count);
  assign rd_last = (CNT_W'(rd_addr_r) + CNT_W'(1)) == sts.count;

  // position of the element inserted or removed
  always_comb begin
    case (in_data.kind) inside
      K_INS_BACK:            idx = sts.count[IDX_W-1:0];
      K_DEL_BACK:            idx = cnt_m1[IDX_W-1:0];
      K_INS_POS, K_DEL_POS:  idx = pos_m1[IDX_W-1:0];
      default:               idx = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rd_addr_nxt   = rd_addr_r;
    pend_addr_nxt = pend_addr_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    up_nxt        = up_r;
    status_nxt    = status_r;
    cmd           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          status_nxt  = ST_OK;
          idx_nxt     = idx;
          pend_nxt    = 1'b0;
          first_nxt   = 1'b0;
          left_nxt    = sts.count - CNT_W'(idx);
          unique case (in_data.kind) inside
            K_INS_FRONT, K_INS_BACK, K_INS_POS: begin
              up_nxt      = 1'b1;
              rd_addr_nxt = cnt_m1[IDX_W-1:0];
              if ((in_data.kind == K_INS_POS) && ins_bad) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else if (sts.count >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            K_DEL_FRONT, K_DEL_BACK, K_DEL_POS: begin
              up_nxt      = 1'b0;
              first_nxt   = 1'b1;
              rd_addr_nxt = idx;
              if (sts.count == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else if ((in_data.kind == K_DEL_POS) && del_bad) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            K_READ_ALL: begin
              rd_addr_nxt = '0;
              if (sts.count == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_RD_REQ;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // one read issued and one earlier read retired per cycle
        if (left_r != '0) begin
          cmd.mem_re  = 1'b1;
          cmd.raddr   = rd_addr_r;
          rd_addr_nxt = up_r ? rd_addr_r - IDX_W'(1) : rd_addr_r + IDX_W'(1);
          left_nxt    = left_r - CNT_W'(1);
        end
        if (pend_r) begin
          if (up_r) begin
            cmd.mem_we = 1'b1;
            cmd.waddr  = pend_addr_r + IDX_W'(1);
          end else if (first_r) begin
            cmd.cap_res = 1'b1;
          end else begin
            cmd.mem_we = 1'b1;
            cmd.waddr  = pend_addr_r - IDX_W'(1);
          end
        end
        pend_nxt      = left_r != '0;
        pend_addr_nxt = rd_addr_r;
        first_nxt     = first_r && !pend_r;
        if (left_r == '0) begin
          if (up_r) begin
            state_nxt = S_PUT;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_EMIT;
          end
        end
      end

      S_PUT: begin
        cmd.mem_we   = 1'b1;
        cmd.waddr    = idx_r;
        cmd.wsel_val = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RD_REQ: begin
        cmd.mem_re = 1'b1;
        cmd.raddr  = rd_addr_r;
        state_nxt  = S_RD_EMIT;
      end

      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_sel_rd = 1'b1;
          cmd.out_last   = rd_last;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_addr_nxt = rd_addr_r + IDX_W'(1);
            state_nxt   = S_RD_REQ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_r   <= 1'b0;
      first_r  <= 1'b0;
      up_r     <= 1'b0;
      left_r   <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      up_r     <= up_nxt;
      left_r   <= left_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    idx_r       <= idx_nxt;
  end

  assign in_stall = state_r != S_IDLE;

endmodule

>>> hw/rtl/positional_list_store.sv
// top level of the positional list store
// depends on pls_pkg, pls_ctrl and pls_dp
//
// an ordered list of up to 16 signed 32-bit values held packed in list order
// in a two-port element memory (one write and one registered read per
// cycle). each input transaction is one operation: insert at front, back or
// a 1-based position, delete from front, back or a position (the deleted
// value is returned), or read out the whole list. every operation gives one
// result transaction with last set, except read-all, which gives one per
// element, front first, with last on the final one. status reports ok, full,
// empty or bad position; element_count is the count after the operation.
// sequence with no output stall: an insert moves each element at or after
// its index i up one place, one memory move per cycle, then drains the last
// move, writes the new value and loads the result; a delete returns the
// element at index i, moves each later element down one place, then drains
// the last move with the count update and loads the result; errors, an
// empty read-out and kind 7 go straight to the result load; a read-all does
// one memory read and then one output load per element. a stalled output
// register holds the result load back by the length of the stall.
// the next input is taken once the final result of an operation is loaded
// into the output register, even while that result is still stalled. the
// element memory is not cleared at reset; only entries below the count are
// ever read
module positional_list_store (
  input  logic          clk,
  input  logic          rst_n,
  // input transactions
  input  logic          in_valid,
  input  pls_pkg::in_t  in_data,
  output logic          in_stall,
  // result transactions
  output logic          out_valid,
  output pls_pkg::out_t out_data,
  input  logic          out_stall
);
  import pls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, error checks, shift and read-out stepping
  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // storage, element count and the output register
  pls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_data.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
